### hdl/drdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drdd_pkg
// Types, constants and per-stage binary64 arithmetic steps for the decimal
// digit rounding pipeline.
// ----------------------------------------------------------------------------
package drdd_pkg;

    localparam logic [1:0] MODE_CHECKED   = 2'd0;
    localparam logic [1:0] MODE_UNCHECKED = 2'd1;
    localparam logic [1:0] MODE_AWAY      = 2'd2;

    localparam logic [0:0] REG_DIGITS = 1'b0;
    localparam logic [0:0] REG_MODE   = 1'b1;

    localparam logic [4:0]  MAX_DIGITS = 5'd23;
    localparam logic [63:0] MAGIC      = 64'h4338000000000000;
    localparam logic [63:0] NEG_MAGIC  = 64'hC338000000000000;
    localparam logic [63:0] CAST_LIMIT = 64'h43DFFFFFFFFFFFFF;
    localparam logic [63:0] SIGN_MASK  = 64'h8000000000000000;
    localparam logic [63:0] QUIET_BIT  = 64'h0008000000000000;
    localparam logic [63:0] ONE        = 64'h3FF0000000000000;

    typedef struct packed {
        logic        valid;
        logic [63:0] orig;
        logic [4:0]  k;
        logic        away;
        logic        flagged;
        logic        isnan;
        logic [63:0] aux;
    } tag_t;

    typedef struct packed {
        logic        sign;
        logic        inf;
        logic        zero;
        logic [12:0] esum;
        logic [53:0] pp_hh;
        logic [52:0] pp_hl;
        logic [52:0] pp_lh;
        logic [51:0] pp_ll;
    } mul_pp_t;

    typedef struct packed {
        logic         sign;
        logic         inf;
        logic         zero;
        logic [12:0]  esum;
        logic [105:0] prod;
    } mul_prod_t;

    typedef struct packed {
        mul_prod_t  p;
        logic [6:0] lz;
    } mul_lz_t;

    typedef struct packed {
        logic         sign;
        logic         inf;
        logic         zero;
        logic         ovf;
        logic [10:0]  field;
        logic [105:0] sh;
        logic         stk;
    } mul_norm_t;

    typedef struct packed {
        logic        sign;
        logic        eff_sub;
        logic        inf;
        logic        inf_sign;
        logic        both_zero;
        logic        zero_sign;
        logic [10:0] ebig;
    } add_ctl_t;

    typedef struct packed {
        add_ctl_t    ctl;
        logic [5:0]  dsh;
        logic [52:0] mbig;
        logic [52:0] msmall;
    } add_unp_t;

    typedef struct packed {
        add_ctl_t    ctl;
        logic [55:0] big;
        logic [55:0] small_m;
    } add_aln_t;

    typedef struct packed {
        add_ctl_t    ctl;
        logic [56:0] sum;
    } add_sum_t;

    typedef struct packed {
        add_ctl_t    ctl;
        logic [56:0] sum;
        logic [5:0]  lz;
    } add_lz_t;

    typedef struct packed {
        add_ctl_t    ctl;
        logic        ovf;
        logic        zero_res;
        logic [10:0] field;
        logic [56:0] sh;
    } add_norm_t;

    function automatic logic [63:0] pow_up(input logic [4:0] k);
        logic [63:0] r;
        case (k)
            5'd0:    r = 64'h3FF0000000000000;
            5'd1:    r = 64'h4024000000000000;
            5'd2:    r = 64'h4059000000000000;
            5'd3:    r = 64'h408F400000000000;
            5'd4:    r = 64'h40C3880000000000;
            5'd5:    r = 64'h40F86A0000000000;
            5'd6:    r = 64'h412E848000000000;
            5'd7:    r = 64'h416312D000000000;
            5'd8:    r = 64'h4197D78400000000;
            5'd9:    r = 64'h41CDCD6500000000;
            5'd10:   r = 64'h4202A05F20000000;
            5'd11:   r = 64'h42374876E8000000;
            5'd12:   r = 64'h426D1A94A2000000;
            5'd13:   r = 64'h42A2309CE5400000;
            5'd14:   r = 64'h42D6BCC41E900000;
            5'd15:   r = 64'h430C6BF526340000;
            5'd16:   r = 64'h4341C37937E08000;
            5'd17:   r = 64'h4376345785D8A000;
            5'd18:   r = 64'h43ABC16D674EC800;
            5'd19:   r = 64'h43E158E460913D00;
            5'd20:   r = 64'h4415AF1D78B58C40;
            5'd21:   r = 64'h444B1AE4D6E2EF50;
            5'd22:   r = 64'h4480F0CF064DD592;
            default: r = 64'h44B52D02C7E14AF6;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pow_dn(input logic [4:0] k);
        logic [63:0] r;
        case (k)
            5'd0:    r = 64'h3FF0000000000000;
            5'd1:    r = 64'h3FB999999999999A;
            5'd2:    r = 64'h3F847AE147AE147B;
            5'd3:    r = 64'h3F50624DD2F1A9FC;
            5'd4:    r = 64'h3F1A36E2EB1C432D;
            5'd5:    r = 64'h3EE4F8B588E368F1;
            5'd6:    r = 64'h3EB0C6F7A0B5ED8D;
            5'd7:    r = 64'h3E7AD7F29ABCAF48;
            5'd8:    r = 64'h3E45798EE2308C3A;
            5'd9:    r = 64'h3E112E0BE826D695;
            5'd10:   r = 64'h3DDB7CDFD9D7BDBB;
            5'd11:   r = 64'h3DA5FD7FE1796495;
            5'd12:   r = 64'h3D719799812DEA11;
            5'd13:   r = 64'h3D3C25C268497682;
            5'd14:   r = 64'h3D06849B86A12B9B;
            5'd15:   r = 64'h3CD203AF9EE75616;
            5'd16:   r = 64'h3C9CD2B297D889BC;
            5'd17:   r = 64'h3C670EF54646D497;
            5'd18:   r = 64'h3C32725DD1D243AC;
            5'd19:   r = 64'h3BFD83C94FB6D2AC;
            5'd20:   r = 64'h3BC79CA10C924223;
            5'd21:   r = 64'h3B92E3B40A0E9B4F;
            5'd22:   r = 64'h3B5E392010175EE6;
            default: r = 64'h3B282DB34012B251;
        endcase
        return r;
    endfunction

    // multiply, stage 1: unpack and partial products of the 27-bit and 26-bit mantissa halves
    function automatic mul_pp_t mul_unpack(input logic [63:0] a, input logic [63:0] b);
        mul_pp_t     r;
        logic [52:0] ma;
        logic [52:0] mb;
        logic [10:0] ea;
        logic [10:0] eb;
        ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        ma = {|a[62:52], a[51:0]};
        mb = {|b[62:52], b[51:0]};
        r.sign  = a[63] ^ b[63];
        r.inf   = (&a[62:52]) | (&b[62:52]);
        r.zero  = (a[62:0] == 63'd0) | (b[62:0] == 63'd0);
        r.esum  = {2'b0, ea} + {2'b0, eb};
        r.pp_hh = ma[52:26] * mb[52:26];
        r.pp_hl = ma[52:26] * mb[25:0];
        r.pp_lh = ma[25:0] * mb[52:26];
        r.pp_ll = ma[25:0] * mb[25:0];
        return r;
    endfunction

    function automatic mul_prod_t mul_sum(input mul_pp_t x);
        mul_prod_t r;
        r.sign = x.sign;
        r.inf  = x.inf;
        r.zero = x.zero;
        r.esum = x.esum;
        r.prod = {x.pp_hh, 52'b0} + {27'b0, x.pp_hl, 26'b0}
               + {27'b0, x.pp_lh, 26'b0} + {54'b0, x.pp_ll};
        return r;
    endfunction

    function automatic mul_lz_t mul_lzc(input mul_prod_t x);
        mul_lz_t r;
        r.p  = x;
        r.lz = 7'd106;
        for (int i = 0; i < 106; i++) begin
            if (x.prod[i]) begin
                r.lz = 7'(105 - i);
            end
        end
        return r;
    endfunction

    function automatic mul_norm_t mul_norm(input mul_lz_t x);
        mul_norm_t          r;
        logic signed [14:0] be;
        logic [233:0]       wide;
        logic [12:0]        lsh;
        logic [9:0]         rs;
        be = $signed({2'b0, x.p.esum}) - 15'sd1022 - $signed({8'b0, x.lz});
        r.sign  = x.p.sign;
        r.inf   = x.p.inf;
        r.zero  = x.p.zero;
        r.ovf   = (be >= 15'sd2047);
        r.field = 11'd0;
        r.stk   = 1'b0;
        r.sh    = x.p.prod;
        if (be >= 15'sd1) begin
            r.sh    = x.p.prod << x.lz;
            r.field = be[10:0];
        end else if (x.p.esum >= 13'd1023) begin
            lsh  = x.p.esum - 13'd1023;
            r.sh = x.p.prod << lsh;
        end else begin
            rs = 10'(13'd1023 - x.p.esum);
            if (rs > 10'd127) begin
                rs = 10'd127;
            end
            wide  = {x.p.prod, 128'b0} >> rs;
            r.sh  = wide[233:128];
            r.stk = |wide[127:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] mul_round(input mul_norm_t x);
        logic [62:0] pack;
        logic        inc;
        logic [63:0] r;
        inc  = x.sh[52] & (x.sh[53] | (|x.sh[51:0]) | x.stk);
        pack = {x.field, x.sh[104:53]} + {62'b0, inc};
        if (x.inf || x.ovf) begin
            r = {x.sign, 11'h7FF, 52'b0};
        end else if (x.zero) begin
            r = {x.sign, 63'b0};
        end else begin
            r = {x.sign, pack};
        end
        return r;
    endfunction

    // add, stage 1: unpack, order by magnitude and find the alignment shift
    function automatic add_unp_t add_unpack(input logic [63:0] a, input logic [63:0] b);
        add_unp_t    r;
        logic [63:0] big;
        logic [63:0] sml;
        logic [10:0] es;
        logic [11:0] d;
        if (b[62:0] > a[62:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        r.ctl.sign      = big[63];
        r.ctl.eff_sub   = a[63] ^ b[63];
        r.ctl.inf       = (&a[62:52]) | (&b[62:52]);
        r.ctl.inf_sign  = (&a[62:52]) ? a[63] : b[63];
        r.ctl.both_zero = (a[62:0] == 63'd0) & (b[62:0] == 63'd0);
        r.ctl.zero_sign = a[63] & b[63];
        r.ctl.ebig      = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es              = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        r.mbig          = {|big[62:52], big[51:0]};
        r.msmall        = {|sml[62:52], sml[51:0]};
        d               = {1'b0, r.ctl.ebig} - {1'b0, es};
        r.dsh           = (d > 12'd63) ? 6'd63 : d[5:0];
        return r;
    endfunction

    function automatic add_aln_t add_align(input add_unp_t x);
        add_aln_t     r;
        logic [119:0] wide;
        wide      = {x.msmall, 3'b0, 64'b0} >> x.dsh;
        r.ctl     = x.ctl;
        r.big     = {x.mbig, 3'b0};
        r.small_m = {wide[119:65], wide[64] | (|wide[63:0])};
        return r;
    endfunction

    function automatic add_sum_t add_add(input add_aln_t x);
        add_sum_t r;
        r.ctl = x.ctl;
        if (x.ctl.eff_sub) begin
            r.sum = {1'b0, x.big} - {1'b0, x.small_m};
        end else begin
            r.sum = {1'b0, x.big} + {1'b0, x.small_m};
        end
        return r;
    endfunction

    function automatic add_lz_t add_lzc(input add_sum_t x);
        add_lz_t r;
        r.ctl = x.ctl;
        r.sum = x.sum;
        r.lz  = 6'd57;
        for (int i = 0; i < 57; i++) begin
            if (x.sum[i]) begin
                r.lz = 6'(56 - i);
            end
        end
        return r;
    endfunction

    function automatic add_norm_t add_norm(input add_lz_t x);
        add_norm_t          r;
        logic signed [13:0] be;
        logic [5:0]         s;
        be = $signed({3'b0, x.ctl.ebig}) + 14'sd1 - $signed({8'b0, x.lz});
        if (be >= 14'sd1) begin
            s       = x.lz;
            r.field = be[10:0];
        end else begin
            s       = x.ctl.ebig[5:0];
            r.field = 11'd0;
        end
        r.ctl      = x.ctl;
        r.ovf      = (be >= 14'sd2047);
        r.zero_res = (x.sum == 57'd0);
        r.sh       = x.sum << s;
        return r;
    endfunction

    function automatic logic [63:0] add_round(input add_norm_t x);
        logic [62:0] pack;
        logic        inc;
        logic [63:0] r;
        inc  = x.sh[3] & (x.sh[4] | (|x.sh[2:0]));
        pack = {x.field, x.sh[55:4]} + {62'b0, inc};
        if (x.ctl.inf) begin
            r = {x.ctl.inf_sign, 11'h7FF, 52'b0};
        end else if (x.zero_res) begin
            r = {x.ctl.both_zero & x.ctl.zero_sign, 63'b0};
        end else if (x.ovf) begin
            r = {x.ctl.sign, 11'h7FF, 52'b0};
        end else begin
            r = {x.ctl.sign, pack};
        end
        return r;
    endfunction

    // half away from zero, sign of zero kept
    function automatic logic [63:0] round_away(input logic [63:0] y);
        logic [10:0] e;
        logic [5:0]  sh;
        logic [63:0] mask;
        logic [63:0] half;
        logic [63:0] r;
        e = y[62:52];
        if (e >= 11'd1075) begin
            r = y;
        end else if (e == 11'd1022) begin
            r = {y[63], ONE[62:0]};
        end else if (e < 11'd1022) begin
            r = {y[63], 63'b0};
        end else begin
            sh   = 6'(11'd1075 - e);
            mask = (64'd1 << sh) - 64'd1;
            half = 64'd1 << (sh - 6'd1);
            r    = (y + half) & ~mask;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/decimal_digit_round_double.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_round_double
// Rounds binary64 values to a configured number of decimal fraction digits.
// ----------------------------------------------------------------------------
// One transaction per clock in, one per clock out. The path from input accept
// to output valid runs through the input register, a 5-stage multiplier
// (scale up), two 6-stage adders (magic add and subtract, or a bypass for
// half-away rounding), a second 5-stage multiplier (scale down) and the
// output register. Back-pressure on m_tready stalls the whole chain.
// Registers: 0x0 round_digits (0..23, larger saturates), 0x4 round_mode
// (0 checked, 1 unchecked, 2/3 half away from zero).
module decimal_digit_round_double
    import drdd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value_bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [63:0] result_bits
    output logic      [0:0]  m_tuser    // [0] not_encodable
);

    localparam int TagDepth = 23;

    logic [4:0]  digits_reg;
    logic [1:0]  mode_reg;
    logic        pipe_en;
    logic        wr_en;
    logic [4:0]  k_sat;
    logic        flag_in;

    tag_t        tag_reg  [TagDepth];
    tag_t        tag_next [TagDepth];

    mul_pp_t     m1_reg [2];
    mul_prod_t   m2_reg [2];
    mul_lz_t     m3_reg [2];
    mul_norm_t   m4_reg [2];
    logic [63:0] m5_reg [2];
    add_unp_t    a1_reg [2];
    add_aln_t    a2_reg [2];
    add_sum_t    a3_reg [2];
    add_lz_t     a4_reg [2];
    add_norm_t   a5_reg [2];
    logic [63:0] a6_reg [2];

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_ne_reg;
    logic [63:0] out_data_next;
    logic        out_ne_next;

    // configuration
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= 5'd0;
            mode_reg   <= MODE_CHECKED;
        end else if (wr_en) begin
            case (paddr[2])
                REG_DIGITS: digits_reg <= pwdata[4:0];
                REG_MODE:   mode_reg   <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DIGITS: prdata = {27'b0, digits_reg};
            REG_MODE:   prdata = {30'b0, mode_reg};
            default:    prdata = 32'b0;
        endcase
    end

    // pipeline control
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en;

    assign k_sat   = (digits_reg > MAX_DIGITS) ? MAX_DIGITS : digits_reg;
    assign flag_in = (mode_reg == MODE_CHECKED)
                   && ((&s_tdata[62:52]) || (s_tdata[62:0] > CAST_LIMIT[62:0])
                       || (s_tdata == SIGN_MASK));

    always_comb begin
        tag_next[0].valid   = s_tvalid;
        tag_next[0].orig    = s_tdata;
        tag_next[0].k       = k_sat;
        tag_next[0].away    = mode_reg[1];
        tag_next[0].flagged = flag_in;
        tag_next[0].isnan   = (&s_tdata[62:52]) && (s_tdata[51:0] != 52'd0);
        tag_next[0].aux     = 64'd0;
        for (int i = 1; i < TagDepth; i++) begin
            tag_next[i] = tag_reg[i-1];
        end
        tag_next[6].aux = round_away(m5_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TagDepth; i++) begin
                tag_reg[i].valid <= 1'b0;
            end
        end else if (pipe_en) begin
            for (int i = 0; i < TagDepth; i++) begin
                tag_reg[i] <= tag_next[i];
            end
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m1_reg[0] <= mul_unpack(tag_reg[0].orig, pow_up(tag_reg[0].k));
            a1_reg[0] <= add_unpack(m5_reg[0], MAGIC);
            a1_reg[1] <= add_unpack(a6_reg[0], NEG_MAGIC);
            m1_reg[1] <= mul_unpack(tag_reg[17].away ? tag_reg[17].aux : a6_reg[1],
                                    pow_dn(tag_reg[17].k));
            for (int j = 0; j < 2; j++) begin
                m2_reg[j] <= mul_sum(m1_reg[j]);
                m3_reg[j] <= mul_lzc(m2_reg[j]);
                m4_reg[j] <= mul_norm(m3_reg[j]);
                m5_reg[j] <= mul_round(m4_reg[j]);
                a2_reg[j] <= add_align(a1_reg[j]);
                a3_reg[j] <= add_add(a2_reg[j]);
                a4_reg[j] <= add_lzc(a3_reg[j]);
                a5_reg[j] <= add_norm(a4_reg[j]);
                a6_reg[j] <= add_round(a5_reg[j]);
            end
        end
    end

    // output register
    always_comb begin
        out_ne_next = 1'b0;
        if (tag_reg[22].flagged) begin
            out_data_next = tag_reg[22].orig;
            out_ne_next   = 1'b1;
        end else if (tag_reg[22].isnan) begin
            out_data_next = tag_reg[22].orig | QUIET_BIT;
        end else begin
            out_data_next = m5_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= tag_reg[22].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_data_reg <= out_data_next;
            out_ne_reg   <= out_ne_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ne_reg;

`ifndef SYNTHESIS
    a_stall_freezes_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(tag_reg[22]))
        else $error("pipeline tail moved during stall");

    a_tail_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && tag_reg[22].valid |=> out_valid_reg)
        else $error("valid transaction dropped at output");

    a_flag_is_bad_input: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ne_reg |->
            (&out_data_reg[62:52]) || (out_data_reg[62:0] > CAST_LIMIT[62:0])
            || (out_data_reg == SIGN_MASK))
        else $error("flagged result is not an unencodable input");

    a_nan_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ne_reg && (&out_data_reg[62:52])
            && (out_data_reg[51:0] != 52'd0) |-> out_data_reg[51])
        else $error("signaling NaN on output");
`endif

endmodule
`default_nettype wire
